>>> design/rhkl_pkg.sv
// ----------------------------------------------------------------------------
// rhkl_pkg
// Shared types and constants for the Robin Hood key lock table.
// ----------------------------------------------------------------------------
package rhkl_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int MARK_NUM        = 90;
  localparam int MARK_DEN        = 100;
  localparam int KEY_W           = 64;
  localparam int OWNER_W         = 32;
  localparam int CNT_W           = 32;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_HELD    = 3'd1,
    ST_CONFLICT = 3'd2,
    ST_FULL    = 3'd3,
    ST_RELEASED = 3'd4,
    ST_IGNORED = 3'd5
  } lock_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_LK_RD,
    S_LK_EV,
    S_UL_RD,
    S_UL_EV,
    S_SH_RD,
    S_SH_EV,
    S_SH_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic         capture;
    logic         start;
    logic         clr;
    logic         rd;
    logic         place;
    logic         swap;
    logic         advance;
    logic         grant;
    logic         conflict;
    logic         full;
    logic         free;
    logic         move;
    logic         shclr;
    logic         set_st;
    lock_status_t st;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic home_ready;
    logic op;
    logic busy;
    logic hash_eq;
    logic owner_eq;
    logic probe_lt_cp;
    logic almost;
    logic steps_over;
    logic steps_end;
    logic ul_break;
    logic probe_zero;
    logic probe_ge_plen;
    logic displaced;
  } flags_t;

endpackage

>>> design/rhkl_ctrl.sv
// ----------------------------------------------------------------------------
// rhkl_ctrl
// Sequencer: runs the clearing pass after reset, then walks the probe, insert and back-shift steps one slot at a time.
// ----------------------------------------------------------------------------
module rhkl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  rhkl_pkg::flags_t flags,
  output rhkl_pkg::cmd_t  cmd
);
  import rhkl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (flags.clr_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_HOME;
      S_HOME:  if (flags.home_ready) state_next = flags.op ? S_UL_RD : S_LK_RD;
      S_LK_RD: state_next = S_LK_EV;
      S_LK_EV: begin
        if (!flags.busy || flags.steps_over) begin
          state_next = S_DONE;
        end else if (!flags.displaced && flags.hash_eq) begin
          state_next = S_DONE;
        end else if (flags.probe_lt_cp && flags.almost) begin
          state_next = S_DONE;
        end else begin
          state_next = S_LK_RD;
        end
      end
      S_UL_RD: state_next = S_UL_EV;
      S_UL_EV: begin
        if (flags.steps_end || flags.ul_break) begin
          if (!flags.busy || !flags.hash_eq || !flags.owner_eq) state_next = S_DONE;
          else state_next = S_SH_RD;
        end else begin
          state_next = S_UL_RD;
        end
      end
      S_SH_RD: state_next = S_SH_EV;
      S_SH_EV: begin
        if (flags.steps_end || !flags.busy || flags.probe_zero) state_next = S_DONE;
        else if (flags.probe_ge_plen) state_next = S_SH_WR;
        else state_next = S_SH_RD;
      end
      S_SH_WR: state_next = S_SH_RD;
      S_DONE:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.st = ST_GRANTED;
    unique case (state)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE:  cmd.capture = in_valid;
      S_HOME:  cmd.start = flags.home_ready;
      S_LK_RD, S_UL_RD, S_SH_RD: cmd.rd = 1'b1;
      S_LK_EV: begin
        if (!flags.busy) begin
          cmd.place  = 1'b1;
          cmd.grant  = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st     = ST_GRANTED;
        end else if (flags.steps_over) begin
          cmd.full   = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st     = ST_FULL;
        end else if (!flags.displaced && flags.hash_eq) begin
          cmd.set_st   = 1'b1;
          cmd.conflict = !flags.owner_eq;
          cmd.st       = flags.owner_eq ? ST_HELD : ST_CONFLICT;
        end else if (flags.probe_lt_cp && flags.almost) begin
          cmd.full   = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st     = ST_FULL;
        end else begin
          cmd.swap    = flags.probe_lt_cp;
          cmd.advance = 1'b1;
        end
      end
      S_UL_EV: begin
        if (flags.steps_end || flags.ul_break) begin
          if (!flags.busy || !flags.hash_eq || !flags.owner_eq) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_IGNORED;
          end else begin
            cmd.free = 1'b1;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_SH_EV: begin
        if (flags.steps_end || !flags.busy || flags.probe_zero) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_RELEASED;
        end else if (flags.probe_ge_plen) begin
          cmd.move = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_SH_WR: begin
        cmd.shclr   = 1'b1;
        cmd.advance = 1'b1;
      end
      S_DONE:  cmd = '0;
      default: cmd = '0;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

endmodule

>>> design/rhkl_dp.sv
// ----------------------------------------------------------------------------
// rhkl_dp
// Datapath: slot memories, probe registers, home-slot reduction and counters.
// ----------------------------------------------------------------------------
module rhkl_dp #(
  parameter int TABLE_SLOTS = rhkl_pkg::TABLE_SLOTS_DEF,
  localparam int IW = $clog2(TABLE_SLOTS),
  localparam int FULL_MARK_RESET = TABLE_SLOTS * rhkl_pkg::MARK_NUM / rhkl_pkg::MARK_DEN
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rhkl_pkg::cmd_t               cmd,
  output rhkl_pkg::flags_t             flags,
  input  logic                         op,
  input  logic [rhkl_pkg::KEY_W-1:0]   key_hash,
  input  logic [rhkl_pkg::OWNER_W-1:0] owner_id,
  input  logic                         cfg_wr_en,
  input  logic [IW:0]                  cfg_wr_data,
  output logic [2:0]                   status,
  output logic [IW:0]                  occupied,
  output logic [IW-1:0]                max_probe,
  output logic [IW:0]                  max_occupied,
  output logic [rhkl_pkg::CNT_W-1:0]   conflict_count,
  output logic [rhkl_pkg::CNT_W-1:0]   full_count
);
  import rhkl_pkg::*;

  localparam int SW = IW + 2;
  localparam logic [IW:0]   SLOTS_W = (IW+1)'(TABLE_SLOTS);
  localparam logic [SW-1:0] SLOTS_S = SW'(TABLE_SLOTS);
  localparam logic [IW-1:0] LAST    = IW'(TABLE_SLOTS - 1);

  logic [KEY_W-1:0]   mem_hash  [TABLE_SLOTS];
  logic [OWNER_W-1:0] mem_owner [TABLE_SLOTS];
  logic [IW-1:0]      mem_probe [TABLE_SLOTS];
  logic               mem_busy  [TABLE_SLOTS];

  logic [KEY_W-1:0]   rd_hash;
  logic [OWNER_W-1:0] rd_owner;
  logic [IW-1:0]      rd_probe;
  logic               rd_busy;

  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [OWNER_W-1:0] own_q;
  logic [KEY_W-1:0]   c_hash;
  logic [OWNER_W-1:0] c_owner;
  logic [IW:0]        cp;
  logic [IW:0]        plen;
  logic [SW-1:0]      steps;
  logic [IW-1:0]      idx, freed, idx_inc, clr_addr;
  logic               displaced;
  logic [IW:0]        full_mark, occ, occ_peak;
  logic [IW-1:0]      probe_peak;
  logic [CNT_W-1:0]   conflicts, full_refusals;
  lock_status_t       st;
  logic [IW-1:0]      home;
  logic               home_ready;

  logic               we_meta, we_key;
  logic [IW-1:0]      waddr;
  logic               wbusy;
  logic [IW-1:0]      wprobe;
  logic [KEY_W-1:0]   whash;
  logic [OWNER_W-1:0] wowner;

  assign idx_inc = (idx == LAST) ? '0 : idx + 1'b1;

  // home slot: key_hash mod TABLE_SLOTS
  generate
    if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
      assign home       = key_q[IW-1:0];
      assign home_ready = 1'b1;
    end else begin : g_mod
      localparam logic [IW:0] NW = (IW+1)'(TABLE_SLOTS);
      logic [IW-1:0]    rem, rem_next;
      logic [KEY_W-1:0] msh;
      logic [4:0]       mcnt;

      always_comb begin
        logic [IW:0] t;
        rem_next = rem;
        for (int k = 0; k < 4; k++) begin
          t = {rem_next, msh[KEY_W-1-k]};
          if (t >= NW) t = t - NW;
          rem_next = t[IW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          mcnt <= 5'd16;
        end else if (cmd.capture) begin
          mcnt <= '0;
        end else if (mcnt != 5'd16) begin
          mcnt <= mcnt + 5'd1;
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          rem <= '0;
          msh <= key_hash;
        end else if (mcnt != 5'd16) begin
          rem <= rem_next;
          msh <= {msh[KEY_W-5:0], 4'b0000};
        end
      end

      assign home       = rem;
      assign home_ready = (mcnt == 5'd16);
    end
  endgenerate

  // one write port shared by clear, insert, swap, release and back-shift
  always_comb begin
    we_meta = 1'b0;
    we_key  = 1'b0;
    waddr   = idx;
    wbusy   = 1'b0;
    wprobe  = '0;
    whash   = c_hash;
    wowner  = c_owner;
    if (cmd.clr) begin
      we_meta = 1'b1;
      waddr   = clr_addr;
    end else if (cmd.place || cmd.swap) begin
      we_meta = 1'b1;
      we_key  = 1'b1;
      wbusy   = 1'b1;
      wprobe  = cp[IW-1:0];
    end else if (cmd.move) begin
      we_meta = 1'b1;
      we_key  = 1'b1;
      waddr   = freed;
      wbusy   = 1'b1;
      wprobe  = IW'({1'b0, rd_probe} - plen);
      whash   = rd_hash;
      wowner  = rd_owner;
    end else if (cmd.free || cmd.shclr) begin
      we_meta = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we_meta) begin
      mem_busy[waddr]  <= wbusy;
      mem_probe[waddr] <= wprobe;
    end
    if (we_key) begin
      mem_hash[waddr]  <= whash;
      mem_owner[waddr] <= wowner;
    end
    if (cmd.rd) begin
      rd_busy  <= mem_busy[idx];
      rd_probe <= mem_probe[idx];
      rd_hash  <= mem_hash[idx];
      rd_owner <= mem_owner[idx];
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      key_q   <= key_hash;
      own_q   <= owner_id;
      c_hash  <= key_hash;
      c_owner <= owner_id;
    end else if (cmd.swap) begin
      c_hash  <= rd_hash;
      c_owner <= rd_owner;
    end

    if (cmd.start) begin
      idx       <= home;
      steps     <= '0;
      cp        <= '0;
      plen      <= '0;
      displaced <= 1'b0;
    end else begin
      if (cmd.free) begin
        idx   <= idx_inc;
        steps <= '0;
        plen  <= (IW+1)'(1);
        freed <= idx;
      end else if (cmd.advance) begin
        idx   <= idx_inc;
        steps <= steps + 1'b1;
        cp    <= cmd.swap ? {1'b0, rd_probe} + 1'b1 : cp + 1'b1;
        plen  <= cmd.shclr ? (IW+1)'(1) : plen + 1'b1;
        if (cmd.shclr) freed <= idx;
      end
      if (cmd.swap) displaced <= 1'b1;
    end

    if (cmd.set_st) st <= cmd.st;
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      full_mark     <= (IW+1)'(FULL_MARK_RESET);
      occ           <= '0;
      occ_peak      <= '0;
      probe_peak    <= '0;
      conflicts     <= '0;
      full_refusals <= '0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + 1'b1;
      if (cfg_wr_en) full_mark <= cfg_wr_data;
      if (cmd.grant) begin
        occ <= occ + 1'b1;
        if (occ + 1'b1 > occ_peak) occ_peak <= occ + 1'b1;
        if (cp > {1'b0, probe_peak}) probe_peak <= cp[IW-1:0];
      end else if (cmd.free && occ != '0) begin
        occ <= occ - 1'b1;
      end
      if (cmd.conflict) conflicts <= conflicts + 1'b1;
      if (cmd.full) full_refusals <= full_refusals + 1'b1;
    end
  end

  always_comb begin
    flags.clr_last      = (clr_addr == LAST);
    flags.home_ready    = home_ready;
    flags.op            = op_q;
    flags.busy          = rd_busy;
    flags.hash_eq       = (rd_hash == key_q);
    flags.owner_eq      = (rd_owner == own_q);
    flags.probe_lt_cp   = ({1'b0, rd_probe} < cp);
    flags.almost        = (occ >= full_mark) || (occ >= SLOTS_W);
    flags.steps_over    = (steps > SLOTS_S);
    flags.steps_end     = (steps == SLOTS_S);
    flags.ul_break      = !rd_busy || (rd_hash == key_q) || ({1'b0, rd_probe} < plen);
    flags.probe_zero    = (rd_probe == '0);
    flags.probe_ge_plen = ({1'b0, rd_probe} >= plen);
    flags.displaced     = displaced;
  end

  assign status         = st;
  assign occupied       = occ;
  assign max_probe      = probe_peak;
  assign max_occupied   = occ_peak;
  assign conflict_count = conflicts;
  assign full_count     = full_refusals;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= SLOTS_W)
    else $error("occupancy above table size");
  a_peak_ge: assert property (@(posedge clk) disable iff (rst) occ_peak >= occ)
    else $error("occupancy peak below occupancy");
  a_grant_free: assert property (@(posedge clk) disable iff (rst)
      cmd.grant |=> occ == $past(occ) + 1'b1)
    else $error("grant did not raise occupancy");
  a_move_addr: assert property (@(posedge clk) disable iff (rst)
      cmd.move |-> freed != idx)
    else $error("back-shift moved an entry onto itself");

endmodule

>>> design/robin_hood_key_lock_table.sv
// Steps: each slot probed is read, then evaluated; a releasing unlock then reads each
//   back-shift slot and writes each moved entry; a non power-of-two table adds a modulo reduction.
// Throughput: one request at a time; the next request is taken only after the response is accepted.
// Reset: synchronous; a clearing pass empties every slot of the table before the
//   first request is taken. full_mark resets to 90% of TABLE_SLOTS.
// ----------------------------------------------------------------------------
// robin_hood_key_lock_table
// Lock table keyed by 64-bit hash, Robin Hood open addressing with back-shift delete.
// ----------------------------------------------------------------------------
module robin_hood_key_lock_table #(
  parameter int TABLE_SLOTS = rhkl_pkg::TABLE_SLOTS_DEF,
  localparam int IW = $clog2(TABLE_SLOTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [IW:0]                  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [rhkl_pkg::KEY_W-1:0]   key_hash,
  input  logic [rhkl_pkg::OWNER_W-1:0] owner_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [IW:0]                  occupied,
  output logic [IW-1:0]                max_probe,
  output logic [IW:0]                  max_occupied,
  output logic [rhkl_pkg::CNT_W-1:0]   conflict_count,
  output logic [rhkl_pkg::CNT_W-1:0]   full_count
);
  import rhkl_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  rhkl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  rhkl_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .flags          (flags),
    .op             (op),
    .key_hash       (key_hash),
    .owner_id       (owner_id),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .status         (status),
    .occupied       (occupied),
    .max_probe      (max_probe),
    .max_occupied   (max_occupied),
    .conflict_count (conflict_count),
    .full_count     (full_count)
  );

endmodule
